@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and ring index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	// storage geometry
	localparam int CAPACITY    = 64;
	localparam int MAX_RESULTS = 64;
	localparam int DATA_W      = 32;
	localparam int OCC_W       = 7;
	localparam int PTR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	// number of entries a dump emits at most
	localparam int DUMP_MAX    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

	// opcodes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DUMP       = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_ENTRY = 2'd3
	} status_t;

	// input item
	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] value;
	} item_t;

	// result item
	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic [OCC_W-1:0]         occupancy;
		logic                     last;
	} result_t;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_PUSH_FRONT,
		CMD_PUSH_BACK,
		CMD_POP_FRONT,
		CMD_POP_BACK,
		CMD_DUMP_FIRST,
		CMD_DUMP_NEXT
	} cmd_t;

	// datapath status towards the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic first_last;  // a dump holds a single entry
		logic next_last;   // the next dump read is the final one
	} dp_status_t;

	// registered result control from the controller
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    last;
		logic    use_ram;
	} rsp_ctl_t;

	// ring helpers
	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
		input logic [PTR_W-1:0] o);
		logic [PTR_W:0] sum;
		sum = {1'b0, p} + {1'b0, o};
		if (sum >= (PTR_W+1)'(CAPACITY)) begin
			sum = sum - (PTR_W+1)'(CAPACITY);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: decodes accepted items into datapath commands, sequences a
// dump over the stored entries and registers the result control.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          opcode,
	input  deq_pkg::dp_status_t dp_st,
	output logic                busy,
	output deq_pkg::cmd_t       cmd,
	output deq_pkg::rsp_ctl_t   rsp
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t            state_q, state_d;
	deq_pkg::rsp_ctl_t rsp_q, rsp_d;

	assign busy = (state_q == S_DUMP);
	assign rsp  = rsp_q;

	// command decode and next state
	always_comb begin
		state_d       = state_q;
		cmd           = deq_pkg::CMD_NONE;
		rsp_d.valid   = 1'b0;
		rsp_d.status  = deq_pkg::ST_DONE;
		rsp_d.last    = 1'b1;
		rsp_d.use_ram = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					rsp_d.valid = 1'b1;
					case (opcode)
						deq_pkg::OP_PUSH_FRONT: begin
							if (dp_st.full) begin
								rsp_d.status = deq_pkg::ST_FULL;
							end else begin
								cmd = deq_pkg::CMD_PUSH_FRONT;
							end
						end
						deq_pkg::OP_PUSH_BACK: begin
							if (dp_st.full) begin
								rsp_d.status = deq_pkg::ST_FULL;
							end else begin
								cmd = deq_pkg::CMD_PUSH_BACK;
							end
						end
						deq_pkg::OP_POP_FRONT: begin
							if (dp_st.empty) begin
								rsp_d.status = deq_pkg::ST_EMPTY;
							end else begin
								cmd           = deq_pkg::CMD_POP_FRONT;
								rsp_d.use_ram = 1'b1;
							end
						end
						deq_pkg::OP_POP_BACK: begin
							if (dp_st.empty) begin
								rsp_d.status = deq_pkg::ST_EMPTY;
							end else begin
								cmd           = deq_pkg::CMD_POP_BACK;
								rsp_d.use_ram = 1'b1;
							end
						end
						deq_pkg::OP_DUMP: begin
							if (dp_st.empty) begin
								rsp_d.status = deq_pkg::ST_EMPTY;
							end else begin
								cmd           = deq_pkg::CMD_DUMP_FIRST;
								rsp_d.status  = deq_pkg::ST_ENTRY;
								rsp_d.use_ram = 1'b1;
								rsp_d.last    = dp_st.first_last;
								if (!dp_st.first_last) begin
									state_d = S_DUMP;
								end
							end
						end
						default: begin
							rsp_d.status = deq_pkg::ST_DONE;
						end
					endcase
				end
			end
			S_DUMP: begin
				cmd           = deq_pkg::CMD_DUMP_NEXT;
				rsp_d.valid   = 1'b1;
				rsp_d.status  = deq_pkg::ST_ENTRY;
				rsp_d.use_ram = 1'b1;
				rsp_d.last    = dp_st.next_last;
				if (dp_st.next_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rsp_q.valid   <= 1'b0;
			rsp_q.status  <= deq_pkg::ST_DONE;
			rsp_q.last    <= 1'b0;
			rsp_q.use_ram <= 1'b0;
		end else begin
			state_q <= state_d;
			rsp_q   <= rsp_d;
		end
	end

endmodule

@@ rtl/deq_dpath.sv @@
// ----------------------------------------------------------------------------
// deq_dpath
// Datapath: ring store, front pointer, element count and dump offset.
// ----------------------------------------------------------------------------
module deq_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  deq_pkg::cmd_t                        cmd,
	input  logic signed [deq_pkg::DATA_W-1:0]    value,
	input  logic                                 use_ram,
	output deq_pkg::dp_status_t                  dp_st,
	output logic signed [deq_pkg::DATA_W-1:0]    data,
	output logic [deq_pkg::OCC_W-1:0]            occupancy
);

	logic [deq_pkg::PTR_W-1:0]  front_q;
	logic [deq_pkg::CNT_W-1:0]  count_q;
	logic [deq_pkg::CNT_W-1:0]  dcnt_q;
	logic [deq_pkg::CNT_W-1:0]  cnt_m1;
	logic [deq_pkg::CNT_W-1:0]  dump_lim;
	logic [deq_pkg::PTR_W-1:0]  front_dec;
	logic                       we;
	logic                       re;
	logic [deq_pkg::PTR_W-1:0]  waddr;
	logic [deq_pkg::PTR_W-1:0]  raddr;
	logic [deq_pkg::DATA_W-1:0] rdata;

	assign cnt_m1    = count_q - deq_pkg::CNT_W'(1);
	assign front_dec = deq_pkg::ring_dec(front_q);
	assign dump_lim  = (count_q > deq_pkg::CNT_W'(deq_pkg::DUMP_MAX)) ?
		deq_pkg::CNT_W'(deq_pkg::DUMP_MAX) : count_q;

	// status towards the controller
	assign dp_st.empty      = (count_q == '0);
	assign dp_st.full       = (count_q >= deq_pkg::CNT_W'(deq_pkg::CAPACITY));
	assign dp_st.first_last = (dump_lim == deq_pkg::CNT_W'(1));
	assign dp_st.next_last  = ((dcnt_q + deq_pkg::CNT_W'(1)) == dump_lim);

	// store address selection
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = front_q;
		raddr = front_q;
		case (cmd)
			deq_pkg::CMD_PUSH_FRONT: begin
				we    = 1'b1;
				waddr = front_dec;
			end
			deq_pkg::CMD_PUSH_BACK: begin
				we    = 1'b1;
				waddr = deq_pkg::ring_add(front_q, count_q[deq_pkg::PTR_W-1:0]);
			end
			deq_pkg::CMD_POP_FRONT: begin
				re = 1'b1;
			end
			deq_pkg::CMD_POP_BACK: begin
				re    = 1'b1;
				raddr = deq_pkg::ring_add(front_q, cnt_m1[deq_pkg::PTR_W-1:0]);
			end
			deq_pkg::CMD_DUMP_FIRST: begin
				re = 1'b1;
			end
			deq_pkg::CMD_DUMP_NEXT: begin
				re    = 1'b1;
				raddr = deq_pkg::ring_add(front_q, dcnt_q[deq_pkg::PTR_W-1:0]);
			end
			default: begin
				we = 1'b0;
				re = 1'b0;
			end
		endcase
	end

	// pointer, count and dump offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			dcnt_q  <= '0;
		end else begin
			case (cmd)
				deq_pkg::CMD_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + deq_pkg::CNT_W'(1);
				end
				deq_pkg::CMD_PUSH_BACK: begin
					count_q <= count_q + deq_pkg::CNT_W'(1);
				end
				deq_pkg::CMD_POP_FRONT: begin
					front_q <= deq_pkg::ring_inc(front_q);
					count_q <= cnt_m1;
				end
				deq_pkg::CMD_POP_BACK: begin
					count_q <= cnt_m1;
				end
				deq_pkg::CMD_DUMP_FIRST: begin
					dcnt_q <= deq_pkg::CNT_W'(1);
				end
				deq_pkg::CMD_DUMP_NEXT: begin
					dcnt_q <= dcnt_q + deq_pkg::CNT_W'(1);
				end
				default: begin
					dcnt_q <= dcnt_q;
				end
			endcase
		end
	end

	// ring store
	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(deq_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// result payload
	assign data      = use_ram ? rdata : '0;
	assign occupancy = deq_pkg::OCC_W'(count_q);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
		else $error("element count above capacity");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_POP_BACK) |-> (count_q != '0))
		else $error("pop issued on empty store");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == deq_pkg::CMD_PUSH_FRONT || cmd == deq_pkg::CMD_PUSH_BACK) |=>
		(count_q == $past(count_q) + deq_pkg::CNT_W'(1)))
		else $error("push did not raise the count");

	a_dump_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == deq_pkg::CMD_DUMP_NEXT) |-> (dcnt_q < dump_lim))
		else $error("dump offset past the stored entries");
`endif

endmodule

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Each result appears in the cycle after its item is accepted.
// Push, pop and unassigned opcodes: one item per cycle while busy is low.
// A dump of n entries gives n results on consecutive cycles, one per read
// of the store's single read port; busy is high while later reads issue.
// Reset clears the front pointer, count and dump offset; store contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  deq_pkg::item_t   item,
	output logic             valid,
	output deq_pkg::result_t result
);

	deq_pkg::cmd_t                     cmd;
	deq_pkg::dp_status_t               dp_st;
	deq_pkg::rsp_ctl_t                 rsp;
	logic signed [deq_pkg::DATA_W-1:0] data;
	logic [deq_pkg::OCC_W-1:0]         occupancy;

	// controller
	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(item.opcode),
		.dp_st (dp_st),
		.busy  (busy),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	// datapath
	deq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (item.value),
		.use_ram  (rsp.use_ram),
		.dp_st    (dp_st),
		.data     (data),
		.occupancy(occupancy)
	);

	// result transfer
	assign valid            = rsp.valid;
	assign result.status    = rsp.status;
	assign result.data      = data;
	assign result.occupancy = occupancy;
	assign result.last      = rsp.last;

endmodule
